@@ sv/pvt_pkg.sv @@
// Shared constants and types for the perspective vertex transform unit.
package pvt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int COORD_W       = 32;

    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]     t_cfg_data;
    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_cfg_data MAT_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

endpackage

@@ sv/pvt_div_lane.sv @@
// Pipelined restoring divider lane: trunc(c * 2^FRAC_BITS / w), saturated, with bypass.
module pvt_div_lane #(
    parameter int FRAC_BITS = pvt_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  pvt_pkg::t_coord i_c,
    input  pvt_pkg::t_coord i_w,
    input  logic           i_bypass,
    output pvt_pkg::t_coord o_q
);
    import pvt_pkg::*;

    localparam int NB = COORD_W + FRAC_BITS;

    logic [COORD_W-1:0] r_rem [NB+1];
    logic [NB-1:0]      r_nq  [NB+1];
    logic [COORD_W-1:0] r_den [NB+1];
    logic               r_neg [NB+1];
    logic               r_byp [NB+1];
    t_coord             r_c   [NB+1];
    t_coord             r_q;

    logic [COORD_W-1:0] c_mag;
    logic [COORD_W-1:0] w_mag;
    logic [NB-1:0]      q;
    logic               q_hi;
    t_coord             n_q;

    assign c_mag = i_c[COORD_W-1] ? COORD_W'(-i_c) : COORD_W'(i_c);
    assign w_mag = i_w[COORD_W-1] ? COORD_W'(-i_w) : COORD_W'(i_w);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_nq[0]  <= {c_mag, {FRAC_BITS{1'b0}}};
        r_den[0] <= w_mag;
        r_neg[0] <= i_c[COORD_W-1] ^ i_w[COORD_W-1];
        r_byp[0] <= i_bypass;
        r_c[0]   <= i_c;
    end

    for (genvar g = 0; g < NB; g++) begin : g_step
        logic [COORD_W:0] trial;
        logic [COORD_W:0] diff;
        logic             take;
        assign trial = {r_rem[g], r_nq[g][NB-1]};
        assign diff  = trial - {1'b0, r_den[g]};
        assign take  = trial >= {1'b0, r_den[g]};
        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= take ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            r_nq[g+1]  <= {r_nq[g][NB-2:0], take};
            r_den[g+1] <= r_den[g];
            r_neg[g+1] <= r_neg[g];
            r_byp[g+1] <= r_byp[g];
            r_c[g+1]   <= r_c[g];
        end
    end

    assign q    = r_nq[NB];
    assign q_hi = |q[NB-1:COORD_W];

    always_comb begin
        if (r_byp[NB]) begin
            n_q = r_c[NB];
        end else if (r_neg[NB]) begin
            if (q_hi || (q[COORD_W-1] && |q[COORD_W-2:0])) begin
                n_q = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n_q = t_coord'(-q[COORD_W-1:0]);
            end
        end else begin
            if (q_hi || q[COORD_W-1]) begin
                n_q = {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                n_q = t_coord'(q[COORD_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ sv/perspective_vertex_transform_unit.sv @@
// Top level: 4x4 matrix transform of a fixed-point vertex with perspective divide.
// Usage:
//   Write the eight 64-bit matrix registers through i_cfg_we/i_cfg_idx/i_cfg_data
//   (two signed entries per register, column-major) while no vertex is in flight.
//   Present a vertex on i_px/i_py/i_pz with start; it is taken at an edge where
//   start is high and busy is low. busy is high during reset and at the first
//   edge after it, so from then on one vertex can enter in every cycle.
//   Each result appears on o_qx/o_qy/o_qz/o_w_was_zero for one cycle, marked by
//   o_strobe. The pipeline is three stages of multiply, sum and bias/saturate,
//   then a restoring divider that resolves one quotient bit per stage over
//   32 + FRAC_BITS stages, plus its entry and exit registers.
//   Throughput is one vertex per cycle; results leave in order.
//   Reset loads the identity matrix and empties the pipeline.
//   The receiver cannot stall: every beat on o_strobe must be taken.
module perspective_vertex_transform_unit #(
    parameter int FRAC_BITS = pvt_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  pvt_pkg::t_cfg_idx  i_cfg_idx,
    input  pvt_pkg::t_cfg_data i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  pvt_pkg::t_coord    i_px,
    input  pvt_pkg::t_coord    i_py,
    input  pvt_pkg::t_coord    i_pz,
    output logic               o_strobe,
    output pvt_pkg::t_coord    o_qx,
    output pvt_pkg::t_coord    o_qy,
    output pvt_pkg::t_coord    o_qz,
    output logic               o_w_was_zero
);
    import pvt_pkg::*;

    localparam int NB     = COORD_W + FRAC_BITS;
    localparam int DLY    = NB + 2;
    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam t_coord W_ONE   = t_coord'(1) <<< FRAC_BITS;
    localparam t_coord SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    t_cfg_data r_mat [NUM_REGS];
    logic      r_busy;
    logic      accept;

    logic                     r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0] r_p   [4][3];
    logic signed [SUM_W-1:0]  r_s   [4];
    t_coord                   r_row [4];
    logic                     r_zero3;
    logic                     r_byp3;
    logic                     r_dv  [DLY];
    logic                     r_dz  [DLY];

    t_coord                   coord [3];
    t_coord                   ent   [16];
    logic signed [SUM_W-1:0]  fsum  [4];
    t_coord                   n_row [4];
    t_coord                   q     [3];

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign coord[0] = i_px;
    assign coord[1] = i_py;
    assign coord[2] = i_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            for (int i = 0; i < NUM_REGS; i++) r_mat[i] <= MAT_RESET[i];
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_mat[i_cfg_idx] <= i_cfg_data;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            ent[k] = (k % 2 == 1) ? t_coord'(r_mat[k/2][2*COORD_W-1:COORD_W])
                                  : t_coord'(r_mat[k/2][COORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
                r_p[r][j] <= PROD_W'(ent[4*j+r]) * PROD_W'(coord[j]);
            end
            r_s[r] <= SUM_W'(r_p[r][0]) + SUM_W'(r_p[r][1]) + SUM_W'(r_p[r][2]);
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            fsum[r] = (r_s[r] >>> FRAC_BITS) + SUM_W'(ent[12+r]);
            if (fsum[r] > SUM_W'(SAT_MAX)) begin
                n_row[r] = SAT_MAX;
            end else if (fsum[r] < SUM_W'(SAT_MIN)) begin
                n_row[r] = SAT_MIN;
            end else begin
                n_row[r] = t_coord'(fsum[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) r_row[r] <= n_row[r];
        r_zero3 <= n_row[3] == '0;
        r_byp3  <= (n_row[3] == '0) || (n_row[3] == W_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            for (int i = 0; i < DLY; i++) r_dv[i] <= 1'b0;
        end else begin
            r_v1    <= accept;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_dv[0] <= r_v3;
            for (int i = 1; i < DLY; i++) r_dv[i] <= r_dv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dz[0] <= r_zero3;
        for (int i = 1; i < DLY; i++) r_dz[i] <= r_dz[i-1];
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        pvt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk    (i_clk),
            .i_c      (r_row[g]),
            .i_w      (r_row[3]),
            .i_bypass (r_byp3),
            .o_q      (q[g])
        );
    end

    assign o_strobe     = r_dv[DLY-1];
    assign o_w_was_zero = r_dv[DLY-1] && r_dz[DLY-1];
    assign o_qx         = q[0];
    assign o_qy         = q[1];
    assign o_qz         = q[2];

endmodule

@@ sv/pvt_checker.sv @@
// Port-level checker for the perspective vertex transform unit, with its bind.
module pvt_checker #(
    parameter int FRAC_BITS = pvt_pkg::FRAC_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_w_was_zero
);
    localparam int LAT = pvt_pkg::COORD_W + FRAC_BITS + 5;

    a_beat_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted vertex without its result beat");

    a_beat_has_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result beat without an accepted vertex");

    a_flag_needs_strobe: assert property (@(posedge i_clk)
        o_w_was_zero |-> o_strobe)
        else $error("w_was_zero outside a result beat");

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_no_beat_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result beat right after reset");

endmodule

bind perspective_vertex_transform_unit pvt_checker #(.FRAC_BITS(FRAC_BITS)) u_pvt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_w_was_zero (o_w_was_zero)
);
